### hw/rtl/dfgd_pkg.sv
// shared types, constants and skip table for the group delay correction block
`timescale 1ns / 1ps

package dfgd_pkg;

    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 12;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIGITAL_MODE = 3'd0,
        REG_FIRMWARE     = 3'd1,
        REG_DECIMATION   = 3'd2,
        REG_GROUP_DELAY  = 3'd3,
        REG_SWAP_BYTES   = 3'd4
    } reg_idx_t;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_DRAIN  = 1'b1
    } action_t;

    localparam logic        RST_DIGITAL_MODE = 1'b1;
    localparam logic [5:0]  RST_FIRMWARE     = 6'd12;
    localparam logic [11:0] RST_DECIMATION   = 12'd2;
    localparam logic [6:0]  RST_GROUP_DELAY  = 7'd0;
    localparam logic        RST_SWAP_BYTES   = 1'b0;

    localparam logic [5:0] FW_V10     = 6'd10;
    localparam logic [5:0] FW_V11     = 6'd11;
    localparam logic [5:0] FW_V12     = 6'd12;
    localparam logic [5:0] FW_GD_LOW  = 6'd20;
    localparam logic [5:0] FW_GD_HIGH = 6'd23;

    localparam int DECIM_N  = 21;
    localparam int V12_N    = 13;

    localparam logic [11:0] DECIM_KEYS [DECIM_N] = '{
        12'd2, 12'd3, 12'd4, 12'd6, 12'd8, 12'd12, 12'd16, 12'd24, 12'd32, 12'd48,
        12'd64, 12'd96, 12'd128, 12'd192, 12'd256, 12'd384, 12'd512, 12'd768,
        12'd1024, 12'd1536, 12'd2048
    };
    localparam logic [6:0] SKIP_V10 [DECIM_N] = '{
        7'd44, 7'd33, 7'd66, 7'd59, 7'd68, 7'd60, 7'd69, 7'd61, 7'd70, 7'd61, 7'd70,
        7'd61, 7'd70, 7'd61, 7'd70, 7'd61, 7'd70, 7'd61, 7'd70, 7'd61, 7'd70
    };
    localparam logic [6:0] SKIP_V11 [DECIM_N] = '{
        7'd46, 7'd36, 7'd48, 7'd50, 7'd53, 7'd69, 7'd72, 7'd70, 7'd72, 7'd70, 7'd73,
        7'd70, 7'd72, 7'd71, 7'd72, 7'd71, 7'd72, 7'd71, 7'd72, 7'd71, 7'd72
    };
    localparam logic [6:0] SKIP_V12 [V12_N] = '{
        7'd46, 7'd36, 7'd47, 7'd50, 7'd53, 7'd69, 7'd71, 7'd70, 7'd72, 7'd70, 7'd72,
        7'd70, 7'd72
    };

    // work queued for the back end: values to correct, whether a stored pair applies and the last flag
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               use_store;
        logic               last;
    } cmd_t;

    function automatic logic [31:0] byte_swap(input logic [31:0] w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // truncated group delay from the decimation table
    function automatic logic [6:0] table_skip(input logic [11:0] dec, input logic [5:0] fw);
        logic [4:0] k;
        logic       hit;
        logic [6:0] r;
        hit = 1'b0;
        k   = '0;
        r   = '0;
        for (int i = 0; i < DECIM_N; i++)
        begin
            if (DECIM_KEYS[i] == dec)
            begin
                hit = 1'b1;
                k   = i[4:0];
            end
        end
        if (hit)
        begin
            case (fw)
                FW_V10:  r = SKIP_V10[k];
                FW_V11:  r = SKIP_V11[k];
                FW_V12:  r = (k < 5'(V12_N)) ? SKIP_V12[k[3:0]] : 7'd0;
                default: r = 7'd0;
            endcase
        end
        table_skip = r;
    endfunction

endpackage

### hw/rtl/dfgd_ifs.sv
// valid/ready channel interfaces for input pairs and corrected results
`timescale 1ns / 1ps

interface dfgd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] real_word;
    logic [31:0] imag_word;
    logic        final_sample;

    modport source (output valid, output action, output real_word, output imag_word,
                    output final_sample, input ready);
    modport sink (input valid, input action, input real_word, input imag_word,
                  input final_sample, output ready);
endinterface

interface dfgd_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] real_out;
    logic signed [32:0] imag_out;
    logic               last;

    modport source (output valid, output real_out, output imag_out, output last,
                    input ready);
    modport sink (input valid, input real_out, input imag_out, input last,
                  output ready);
endinterface

### hw/rtl/digital_filter_group_delay_correction.sv
// top level of the digital filter group delay correction block
//
//   channel   dir  handshake      transaction contents
//   samples   in   valid/ready    action, real_word, imag_word, final_sample
//   results   out  valid/ready    real_out, imag_out, last
//   cfg       in   cfg_en only    cfg_index, cfg_data
//
// one input transaction per cycle while the command queue is not full; a result passes
// from its input through the queue, the head store read and the output register
// throughput is set by the single read port of the head store, one read per item
// samples.ready drops only when the four entry command queue is full
// reset clears counters, queue and pipeline; head store contents need no clearing
`timescale 1ns / 1ps

module digital_filter_group_delay_correction
    import dfgd_pkg::*;
#(
    parameter int SKIP_DEPTH = 128,
    parameter int MAX_POINTS = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_en,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data,
    dfgd_in_if.sink               samples,
    dfgd_out_if.source            results
);

    localparam int ADDR_W = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
    localparam int Q_W    = $bits(cmd_t) + ADDR_W;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    cmd_t              push_cmd;
    cmd_t              head_cmd;
    logic [ADDR_W-1:0] push_addr;
    logic [ADDR_W-1:0] head_addr;
    logic [Q_W-1:0]    head_word;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [63:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [63:0]       ram_rd_data;
    logic              ended;

    dfgd_front #(
        .SKIP_DEPTH (SKIP_DEPTH),
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .samples     (samples),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_addr      (push_addr),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ended       (ended)
    );

    dfgd_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_cmd, push_addr}),
        .pop       (q_pop),
        .head_data (head_word),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_cmd  = head_word[Q_W-1:ADDR_W];
    assign head_addr = head_word[ADDR_W-1:0];

    dfgd_ram #(
        .WIDTH (64),
        .DEPTH (SKIP_DEPTH)
    ) u_head_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    dfgd_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_addr      (head_addr),
        .q_pop       (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .results     (results)
    );

`ifndef SYNTHESIS
    // the front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // commands only come from accepted input transactions
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (samples.valid && samples.ready))
        else $error("command issued without an input transaction");

    // once the final sample is seen the acquisition stays closed
    a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ended |=> ended)
        else $error("end of acquisition flag cleared");

    // a stored pair that a queued command uses is never written and read in the same cycle at one address
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr) || !head_cmd.use_store)
        else $error("head store read collides with write");
`endif

endmodule

### hw/rtl/dfgd_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module dfgd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/dfgd_queue.sv
// short command queue between the front and back ends
`timescale 1ns / 1ps

module dfgd_queue #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = slots_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

endmodule

### hw/rtl/dfgd_front.sv
// front end: registers, skip latch, counters, head store writes and command issue
`timescale 1ns / 1ps

module dfgd_front
    import dfgd_pkg::*;
#(
    parameter int SKIP_DEPTH = 128,
    parameter int MAX_POINTS = 16384
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data,
    dfgd_in_if.sink              samples,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd,
    output logic [((SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1)-1:0] q_addr,
    output logic                 ram_wr_en,
    output logic [((SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1)-1:0] ram_wr_addr,
    output logic [63:0]          ram_wr_data,
    output logic                 ended
);

    localparam int ADDR_W  = (SKIP_DEPTH > 1) ? $clog2(SKIP_DEPTH) : 1;
    localparam int SKIP_W  = $clog2(SKIP_DEPTH + 1);
    localparam int TAKEN_W = $clog2(2 * SKIP_DEPTH + 1);
    localparam int CW      = (TAKEN_W + 1 > 8) ? TAKEN_W + 1 : 8;
    localparam int GIVEN_W = $clog2(MAX_POINTS + 1);

    logic        dig_reg;
    logic [5:0]  fw_reg;
    logic [11:0] dec_reg;
    logic [6:0]  gd_reg;
    logic        swap_reg;

    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic [SKIP_W-1:0]  drains_reg, drains_next;
    logic [GIVEN_W-1:0] given_reg, given_next;
    logic               ended_reg, ended_next;

    logic               accept;
    logic signed [31:0] re_val;
    logic signed [31:0] im_val;
    logic [6:0]         raw_skip;
    logic [CW-1:0]      skip_calc;
    logic [CW-1:0]      s;
    logic [CW-1:0]      p;
    logic [CW-1:0]      d;
    logic [CW-1:0]      owed;
    logic [CW-1:0]      k;
    logic [CW-1:0]      m;
    logic               emit_req;
    logic               last_req;
    logic               use_store;

    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;
    assign ended         = ended_reg;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg  <= RST_DIGITAL_MODE;
            fw_reg   <= RST_FIRMWARE;
            dec_reg  <= RST_DECIMATION;
            gd_reg   <= RST_GROUP_DELAY;
            swap_reg <= RST_SWAP_BYTES;
        end
        else if (cfg_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DIGITAL_MODE: dig_reg  <= cfg_data[0];
                REG_FIRMWARE:     fw_reg   <= cfg_data[5:0];
                REG_DECIMATION:   dec_reg  <= cfg_data[11:0];
                REG_GROUP_DELAY:  gd_reg   <= cfg_data[6:0];
                REG_SWAP_BYTES:   swap_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        re_val = $signed(swap_reg ? byte_swap(samples.real_word) : samples.real_word);
        im_val = $signed(swap_reg ? byte_swap(samples.imag_word) : samples.imag_word);

        if (!dig_reg)
        begin
            raw_skip = 7'd0;
        end
        else if (fw_reg >= FW_GD_LOW && fw_reg <= FW_GD_HIGH)
        begin
            raw_skip = gd_reg;
        end
        else
        begin
            raw_skip = table_skip(dec_reg, fw_reg);
        end
        skip_calc = (CW'(raw_skip) > CW'(SKIP_DEPTH)) ? CW'(SKIP_DEPTH) : CW'(raw_skip);
    end

    always_comb
    begin
        skip_next   = skip_reg;
        taken_next  = taken_reg;
        drains_next = drains_reg;
        given_next  = given_reg;
        ended_next  = ended_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = {re_val, im_val};
        emit_req    = 1'b0;
        last_req    = 1'b0;
        use_store   = 1'b0;
        k           = '0;
        m           = '0;
        owed        = '0;
        q_push      = 1'b0;
        q_addr      = '0;
        q_cmd       = '0;

        s = (taken_reg == '0) ? skip_calc : CW'(skip_reg);
        p = CW'(taken_reg);
        d = CW'(drains_reg);

        if (accept)
        begin
            if (action_t'(samples.action) == ACT_SAMPLE)
            begin
                if (!ended_reg)
                begin
                    if (taken_reg == '0)
                    begin
                        skip_next = s[SKIP_W-1:0];
                    end
                    // saturating past twice the depth keeps every compare exact
                    if (taken_reg < TAKEN_W'(2 * SKIP_DEPTH))
                    begin
                        taken_next = taken_reg + 1'b1;
                    end
                    if (samples.final_sample)
                    begin
                        ended_next = 1'b1;
                    end
                    if (p < s)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = p[ADDR_W-1:0];
                    end
                    else
                    begin
                        emit_req  = 1'b1;
                        use_store = (p < (s << 1));
                        k         = (s << 1) - 1'b1 - p;
                        last_req  = samples.final_sample && (s == '0);
                        q_cmd.re  = re_val;
                        q_cmd.im  = im_val;
                    end
                end
            end
            else if (ended_reg)
            begin
                owed = (p < s) ? p : s;
                if (d < owed)
                begin
                    emit_req    = 1'b1;
                    drains_next = drains_reg + 1'b1;
                    last_req    = (d + 1'b1 == owed);
                    if (p < s)
                    begin
                        // short acquisition: entries past the last sample read as zero
                        k         = s - 1'b1 - d;
                        use_store = (k < p);
                    end
                    else
                    begin
                        m         = p - s + d;
                        use_store = (m < s);
                        k         = s - 1'b1 - m;
                    end
                end
            end
        end

        if (emit_req)
        begin
            if (given_reg < GIVEN_W'(MAX_POINTS))
            begin
                given_next      = given_reg + 1'b1;
                q_push          = 1'b1;
                q_cmd.use_store = use_store;
                q_cmd.last      = last_req || (given_reg + 1'b1 == GIVEN_W'(MAX_POINTS));
                q_addr          = k[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg   <= '0;
            taken_reg  <= '0;
            drains_reg <= '0;
            given_reg  <= '0;
            ended_reg  <= 1'b0;
        end
        else
        begin
            skip_reg   <= skip_next;
            taken_reg  <= taken_next;
            drains_reg <= drains_next;
            given_reg  <= given_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

### hw/rtl/dfgd_back.sv
// back end: head store read, subtraction and output register
`timescale 1ns / 1ps

module dfgd_back
    import dfgd_pkg::*;
#(
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cmd_t              q_cmd,
    input  logic [ADDR_W-1:0] q_addr,
    output logic              q_pop,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [63:0]       ram_rd_data,
    dfgd_out_if.source        results
);

    logic               s1_valid_reg, s1_valid_next;
    cmd_t               s1_cmd_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [32:0] re_out_reg;
    logic signed [32:0] im_out_reg;
    logic               last_reg;
    logic               s1_adv;
    logic signed [32:0] st_re;
    logic signed [32:0] st_im;
    logic signed [32:0] re_calc;
    logic signed [32:0] im_calc;

    assign s1_adv      = !out_valid_reg || results.ready;
    assign q_pop       = !q_empty && (!s1_valid_reg || s1_adv);
    assign ram_rd_en   = q_pop;
    assign ram_rd_addr = q_addr;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // imaginary part is conjugated, so the stored term enters with a plus sign
    always_comb
    begin
        st_re   = s1_cmd_reg.use_store ? 33'(signed'(ram_rd_data[63:32])) : 33'sd0;
        st_im   = s1_cmd_reg.use_store ? 33'(signed'(ram_rd_data[31:0])) : 33'sd0;
        re_calc = 33'(s1_cmd_reg.re) - st_re;
        im_calc = st_im - 33'(s1_cmd_reg.im);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cmd_reg <= q_cmd;
        end
        if (s1_valid_reg && s1_adv)
        begin
            re_out_reg <= re_calc;
            im_out_reg <= im_calc;
            last_reg   <= s1_cmd_reg.last;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.real_out = re_out_reg;
    assign results.imag_out = im_out_reg;
    assign results.last     = last_reg;

endmodule
